// ===== rtl/drt_pkg.sv =====
// Package for the divider and reload timer.
// Holds the item structs, operation and register codes, and reset constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

	localparam int unsigned NUM_MODES = 4;
	localparam int unsigned SHIFT_W   = 4;
	localparam int unsigned DIV_W     = 16;
	localparam int unsigned ACC_W     = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CLK_W     = 6;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 32;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// timer register select
	localparam logic [1:0] SEL_DIV    = 2'd0;
	localparam logic [1:0] SEL_COUNT  = 2'd1;
	localparam logic [1:0] SEL_RELOAD = 2'd2;
	localparam logic [1:0] SEL_CTRL   = 2'd3;

	// control byte: enable bit and mode field
	localparam int unsigned CTRL_EN_BIT = 2;

	localparam logic [SHIFT_W-1:0] MODE0_RST = 4'd10;
	localparam logic [SHIFT_W-1:0] MODE1_RST = 4'd4;
	localparam logic [SHIFT_W-1:0] MODE2_RST = 4'd6;
	localparam logic [SHIFT_W-1:0] MODE3_RST = 4'd8;

	typedef struct packed {
		logic [1:0]        operation;
		logic [1:0]        reg_select;
		logic [BYTE_W-1:0] write_data;
		logic [CLK_W-1:0]  clocks;
	} cmd_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              timer_irq;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/divider_and_reload_timer.sv =====
// Items pass the input register (stage 1), then the result register.
// Throughput: one item per cycle unless stalled; state updates as an item leaves stage 1.
// cmd_ready drops only while a result waits in the result register and stage 1 is full.
// Reset (arst_n low, asynchronous): divider, accumulator, counter, reload and control
// clear to zero, mode shifts load 10/4/6/8, both stages empty.
// Timer top level; depends on drt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module divider_and_reload_timer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_ready,
	input  wire drt_pkg::cmd_item_t             cmd,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output drt_pkg::rsp_item_t                  rsp,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [drt_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [drt_pkg::PDATA_W-1:0]    pwdata,
	output logic [drt_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	logic [drt_pkg::SHIFT_W-1:0] mode_shift_q [drt_pkg::NUM_MODES];
	logic [drt_pkg::DIV_W-1:0]   div_q;
	logic [drt_pkg::ACC_W-1:0]   acc_q;
	logic [drt_pkg::BYTE_W-1:0]  count_q;
	logic [drt_pkg::BYTE_W-1:0]  reload_q;
	logic [drt_pkg::BYTE_W-1:0]  ctrl_q;

	logic               valid_s1;
	drt_pkg::cmd_item_t item_s1;
	logic               advance;

	logic [drt_pkg::ACC_W:0]     acc_sum;
	logic [drt_pkg::SHIFT_W-1:0] shift;
	logic [drt_pkg::ACC_W:0]     carry;
	logic [drt_pkg::ACC_W:0]     acc_mask;
	logic [drt_pkg::ACC_W+1:0]   cnt_sum;
	logic                        wrap;
	logic                        timer_en;
	drt_pkg::rsp_item_t          rsp_next;

	// config port
	assign pready = 1'b1;
	assign prdata = {{(drt_pkg::PDATA_W-drt_pkg::SHIFT_W){1'b0}}, mode_shift_q[paddr[3:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_shift_q[0] <= drt_pkg::MODE0_RST;
			mode_shift_q[1] <= drt_pkg::MODE1_RST;
			mode_shift_q[2] <= drt_pkg::MODE2_RST;
			mode_shift_q[3] <= drt_pkg::MODE3_RST;
		end else if (psel && penable && pwrite) begin
			mode_shift_q[paddr[3:2]] <= pwdata[drt_pkg::SHIFT_W-1:0];
		end
	end

	// handshake
	assign advance   = valid_s1 && (!rsp_valid || rsp_ready);
	assign cmd_ready = !valid_s1 || !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	// tick arithmetic
	assign timer_en = ctrl_q[drt_pkg::CTRL_EN_BIT];
	assign shift    = mode_shift_q[ctrl_q[1:0]];
	assign acc_sum  = {1'b0, acc_q} + {{(drt_pkg::ACC_W+1-drt_pkg::CLK_W){1'b0}}, item_s1.clocks};
	assign carry    = acc_sum >> shift;
	assign acc_mask = ({{drt_pkg::ACC_W{1'b0}}, 1'b1} << shift) - {{drt_pkg::ACC_W{1'b0}}, 1'b1};
	assign cnt_sum  = {{(drt_pkg::ACC_W+2-drt_pkg::BYTE_W){1'b0}}, count_q} + {1'b0, carry};
	assign wrap     = |cnt_sum[drt_pkg::ACC_W+1:drt_pkg::BYTE_W];

	always_comb begin
		rsp_next = '0;
		unique case (item_s1.operation)
			drt_pkg::OP_TICK: begin
				rsp_next.timer_irq = timer_en && wrap;
			end
			drt_pkg::OP_READ: begin
				unique case (item_s1.reg_select)
					drt_pkg::SEL_DIV:    rsp_next.read_data = div_q[drt_pkg::DIV_W-1:drt_pkg::BYTE_W];
					drt_pkg::SEL_COUNT:  rsp_next.read_data = count_q;
					drt_pkg::SEL_RELOAD: rsp_next.read_data = reload_q;
					default:             rsp_next.read_data = ctrl_q;
				endcase
			end
			default: begin
				rsp_next = '0;
			end
		endcase
	end

	// timer state, updated as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= '0;
			acc_q    <= '0;
			count_q  <= '0;
			reload_q <= '0;
			ctrl_q   <= '0;
		end else if (advance) begin
			unique case (item_s1.operation)
				drt_pkg::OP_TICK: begin
					div_q <= div_q + {{(drt_pkg::DIV_W-drt_pkg::CLK_W){1'b0}}, item_s1.clocks};
					if (timer_en) begin
						acc_q <= acc_sum[drt_pkg::ACC_W-1:0] & acc_mask[drt_pkg::ACC_W-1:0];
						if (wrap) begin
							count_q <= reload_q;
						end else begin
							count_q <= cnt_sum[drt_pkg::BYTE_W-1:0];
						end
					end
				end
				drt_pkg::OP_WRITE: begin
					unique case (item_s1.reg_select)
						drt_pkg::SEL_DIV:    div_q    <= '0;
						drt_pkg::SEL_COUNT:  count_q  <= item_s1.write_data;
						drt_pkg::SEL_RELOAD: reload_q <= item_s1.write_data;
						default:             ctrl_q   <= item_s1.write_data;
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (!rsp_valid || rsp_ready) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp <= rsp_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/drt_checker.sv =====
// Port-level checks for the divider and reload timer, bound to the top level.
// Depends on drt_pkg and divider_and_reload_timer.
`timescale 1ns / 1ps
`default_nettype none

module drt_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_ready,
	input wire drt_pkg::cmd_item_t          cmd,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire drt_pkg::rsp_item_t          rsp,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [drt_pkg::PADDR_W-1:0] paddr,
	input wire logic [drt_pkg::PDATA_W-1:0] pwdata,
	input wire logic [drt_pkg::PDATA_W-1:0] prdata,
	input wire logic                        pready
);

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("cmd_ready low without output stall");

	// an interrupt comes from a tick, which reads nothing
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.timer_irq |-> rsp.read_data == '0)
		else $error("interrupt with read data");

	// mode registers are four bits wide
	a_prdata_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> prdata[drt_pkg::PDATA_W-1:drt_pkg::SHIFT_W] == '0)
		else $error("prdata upper bits set");

	// a written mode reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !(psel && !pwrite && paddr[3:2] == $past(paddr[3:2]))
		|| prdata[drt_pkg::SHIFT_W-1:0] == $past(pwdata[drt_pkg::SHIFT_W-1:0]))
		else $error("mode register readback mismatch");

endmodule

bind divider_and_reload_timer drt_checker u_drt_checker (.*);

`default_nettype wire
